// ----- hdl/fsst_pkg.sv -----
// ---------------------------------------------------------------------------
// fsst_pkg: shared definitions for the floppy sector skew translator
// Widths, register codes, format constants, skew tables and the divider step.
// ---------------------------------------------------------------------------
`default_nettype none

package fsst_pkg;

    localparam int SECTOR_NUMBER_BITS = 16;
    localparam int LS_BITS            = 14;
    localparam int SUM_BITS           = 15;
    localparam int SPT_BITS           = 5;
    localparam int BPS_BITS           = 11;
    localparam int OFFSET_BITS        = 26;
    localparam int DIV_STAGES         = 3;
    localparam int DIV_STEP_BITS      = SUM_BITS / DIV_STAGES;
    localparam int NARROW_BITS        = 8;
    localparam int PIPE_DEPTH         = 8;
    localparam int CFG_INDEX_BITS     = 4;
    localparam int CFG_DATA_BITS      = 12;

    typedef logic [SECTOR_NUMBER_BITS-1:0] sector_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_DISK_INCHES          = 4'd0,
        REG_SIDE_COUNT           = 4'd1,
        REG_SECTORS_PER_TRACK    = 4'd2,
        REG_BYTES_PER_SECTOR     = 4'd3,
        REG_BYTES_PER_GROUP      = 4'd4,
        REG_KILOBYTES_PER_VOLUME = 4'd5,
        REG_RESERVED_SECTORS     = 4'd6,
        REG_ALTERNATE_SKEW       = 4'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [3:0]          disk_inches;
        logic [1:0]          side_count;
        logic [SPT_BITS-1:0] sectors_per_track;
        logic [BPS_BITS-1:0] bytes_per_sector;
        logic [11:0]         bytes_per_group;
        logic [11:0]         kilobytes_per_volume;
        logic [7:0]          reserved_sectors;
        logic                alternate_skew;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        disk_inches:          4'd8,
        side_count:           2'd1,
        sectors_per_track:    5'd26,
        bytes_per_sector:     11'd128,
        bytes_per_group:      12'd1024,
        kilobytes_per_volume: 12'd0,
        reserved_sectors:     8'd0,
        alternate_skew:       1'b0
    };

    localparam logic [3:0]          INCH_5   = 4'd5;
    localparam logic [1:0]          SIDES_2  = 2'd2;
    localparam logic [SPT_BITS-1:0] SPT_5    = 5'd5;
    localparam logic [11:0]         BPG_2048 = 12'd2048;
    localparam logic [11:0]         KB_200   = 12'd200;
    localparam logic [11:0]         KB_320   = 12'd320;
    localparam logic [11:0]         KB_180   = 12'd180;
    localparam logic [BPS_BITS-1:0] BPS_128  = 11'd128;
    localparam logic [BPS_BITS-1:0] BPS_256  = 11'd256;
    localparam logic [BPS_BITS-1:0] BPS_512  = 11'd512;
    localparam logic [BPS_BITS-1:0] BPS_1024 = 11'd1024;

    localparam sector_t TRACK_FOLD = 16'd33;
    localparam sector_t TRACK_TURN = 16'd65;

    // reciprocals for division by 3, 5 and 13, exact for values below 2**17
    localparam logic [15:0] RECIP3  = 16'd43691;
    localparam int          SHIFT3  = 17;
    localparam logic [15:0] RECIP5  = 16'd52429;
    localparam int          SHIFT5  = 18;
    localparam logic [15:0] RECIP13 = 16'd20165;
    localparam int          SHIFT13 = 18;

    localparam int LEN_180  = 18;
    localparam int LEN_DD   = 10;
    localparam int LEN_128  = 26;
    localparam int LEN_256  = 26;
    localparam int LEN_1024 = 8;

    typedef struct packed {
        logic [SUM_BITS-1:0] a;
        logic [SPT_BITS-1:0] rem;
        logic [SUM_BITS-1:0] q;
    } div_stage_t;

    typedef struct packed {
        logic [SUM_BITS-1:0] s;
        sector_t             t;
    } div_word_t;

    typedef struct packed {
        sector_t n;
        sector_t tprod;
        logic    err;
    } skew_word_t;

    // one restoring step: returns {quotient bit, new remainder}
    function automatic logic [SPT_BITS:0] div_step(
        input logic [SPT_BITS-1:0] rem,
        input logic                din,
        input logic [SPT_BITS-1:0] d
    );
        logic [SPT_BITS:0] r;
        logic [SPT_BITS:0] diff;
        r    = {rem, din};
        diff = r - {1'b0, d};
        if (r >= {1'b0, d})
            return {1'b1, diff[SPT_BITS-1:0]};
        else
            return {1'b0, r[SPT_BITS-1:0]};
    endfunction

    function automatic logic [4:0] skew5_180(input logic [4:0] i);
        case (i)
            5'd0:  return 5'd0;   5'd1:  return 5'd11;  5'd2:  return 5'd5;
            5'd3:  return 5'd16;  5'd4:  return 5'd1;   5'd5:  return 5'd12;
            5'd6:  return 5'd6;   5'd7:  return 5'd17;  5'd8:  return 5'd2;
            5'd9:  return 5'd13;  5'd10: return 5'd7;   5'd11: return 5'd9;
            5'd12: return 5'd3;   5'd13: return 5'd14;  5'd14: return 5'd8;
            5'd15: return 5'd10;  5'd16: return 5'd4;   5'd17: return 5'd15;
            default: return 5'd0;
        endcase
    endfunction

    function automatic logic [3:0] skew5_dd(input logic [3:0] i);
        case (i)
            4'd0: return 4'd0;  4'd1: return 4'd7;  4'd2: return 4'd5;
            4'd3: return 4'd3;  4'd4: return 4'd1;  4'd5: return 4'd8;
            4'd6: return 4'd6;  4'd7: return 4'd4;  4'd8: return 4'd2;
            4'd9: return 4'd9;
            default: return 4'd0;
        endcase
    endfunction

    function automatic logic [4:0] skew8_128(input logic [4:0] i);
        case (i)
            5'd0:  return 5'd0;   5'd1:  return 5'd3;   5'd2:  return 5'd6;
            5'd3:  return 5'd9;   5'd4:  return 5'd12;  5'd5:  return 5'd2;
            5'd6:  return 5'd5;   5'd7:  return 5'd8;   5'd8:  return 5'd11;
            5'd9:  return 5'd1;   5'd10: return 5'd4;   5'd11: return 5'd7;
            5'd12: return 5'd10;  5'd13: return 5'd13;  5'd14: return 5'd16;
            5'd15: return 5'd19;  5'd16: return 5'd22;  5'd17: return 5'd25;
            5'd18: return 5'd15;  5'd19: return 5'd18;  5'd20: return 5'd21;
            5'd21: return 5'd24;  5'd22: return 5'd14;  5'd23: return 5'd17;
            5'd24: return 5'd20;  5'd25: return 5'd23;
            default: return 5'd0;
        endcase
    endfunction

    function automatic logic [4:0] skew8_256(input logic [4:0] i);
        case (i)
            5'd0:  return 5'd0;   5'd1:  return 5'd17;  5'd2:  return 5'd9;
            5'd3:  return 5'd13;  5'd4:  return 5'd5;   5'd5:  return 5'd22;
            5'd6:  return 5'd1;   5'd7:  return 5'd18;  5'd8:  return 5'd10;
            5'd9:  return 5'd14;  5'd10: return 5'd6;   5'd11: return 5'd23;
            5'd12: return 5'd2;   5'd13: return 5'd19;  5'd14: return 5'd11;
            5'd15: return 5'd15;  5'd16: return 5'd7;   5'd17: return 5'd24;
            5'd18: return 5'd3;   5'd19: return 5'd20;  5'd20: return 5'd12;
            5'd21: return 5'd16;  5'd22: return 5'd8;   5'd23: return 5'd25;
            5'd24: return 5'd4;   5'd25: return 5'd21;
            default: return 5'd0;
        endcase
    endfunction

    function automatic logic [2:0] skew8_1024(input logic [2:0] i);
        case (i)
            3'd0: return 3'd0;  3'd1: return 3'd5;  3'd2: return 3'd3;
            3'd3: return 3'd4;  3'd4: return 3'd2;  3'd5: return 3'd7;
            3'd6: return 3'd1;  3'd7: return 3'd6;
            default: return 3'd0;
        endcase
    endfunction

endpackage

`default_nettype wire

// ----- hdl/fsst_cfg.sv -----
// ---------------------------------------------------------------------------
// fsst_cfg: disk format register file
// Holds the eight format registers; writes to unknown indexes are dropped.
// ---------------------------------------------------------------------------
`default_nettype none

module fsst_cfg import fsst_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    output cfg_t                      cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_DISK_INCHES:          cfg_next.disk_inches          = cfg_data[3:0];
                REG_SIDE_COUNT:           cfg_next.side_count           = cfg_data[1:0];
                REG_SECTORS_PER_TRACK:    cfg_next.sectors_per_track    = cfg_data[SPT_BITS-1:0];
                REG_BYTES_PER_SECTOR:     cfg_next.bytes_per_sector     = cfg_data[BPS_BITS-1:0];
                REG_BYTES_PER_GROUP:      cfg_next.bytes_per_group      = cfg_data[11:0];
                REG_KILOBYTES_PER_VOLUME: cfg_next.kilobytes_per_volume = cfg_data[11:0];
                REG_RESERVED_SECTORS:     cfg_next.reserved_sectors     = cfg_data[7:0];
                REG_ALTERNATE_SKEW:       cfg_next.alternate_skew       = cfg_data[0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_RESET;
        else
            cfg_reg <= cfg_next;
    end

endmodule

`default_nettype wire

// ----- hdl/fsst_div.sv -----
// ---------------------------------------------------------------------------
// fsst_div: reserved offset add and pipelined track/sector divider
// Restoring division by sectors per track, five quotient bits per stage.
// ---------------------------------------------------------------------------
`default_nettype none

module fsst_div import fsst_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               up_valid,
    output logic               up_ready,
    input  logic [LS_BITS-1:0] logical_sector,
    output logic               dn_valid,
    input  logic               dn_ready,
    output div_word_t          dn_word
);

    div_stage_t st_reg  [DIV_STAGES];
    div_stage_t st_src  [DIV_STAGES];
    logic       vld_reg [DIV_STAGES];
    logic       vld_src [DIV_STAGES];
    logic       rdy     [DIV_STAGES+1];

    assign rdy[DIV_STAGES] = dn_ready;
    assign up_ready        = rdy[0];

    assign st_src[0].a   = SUM_BITS'(logical_sector) + SUM_BITS'(cfg.reserved_sectors);
    assign st_src[0].rem = '0;
    assign st_src[0].q   = '0;
    assign vld_src[0]    = up_valid;

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_stage
        div_stage_t st_next;

        if (k > 0)
        begin : g_link
            assign st_src[k]  = st_reg[k-1];
            assign vld_src[k] = vld_reg[k-1];
        end

        // advance when this stage is empty or the next one takes its word
        assign rdy[k] = !vld_reg[k] || rdy[k+1];

        always_comb
        begin
            logic [SPT_BITS:0] step;
            st_next = st_src[k];
            for (int j = 0; j < DIV_STEP_BITS; j++)
            begin
                step = div_step(st_next.rem,
                                st_next.a[SUM_BITS-1-k*DIV_STEP_BITS-j],
                                cfg.sectors_per_track);
                st_next.rem = step[SPT_BITS-1:0];
                st_next.q[SUM_BITS-1-k*DIV_STEP_BITS-j] = step[SPT_BITS];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (rdy[k])
                vld_reg[k] <= vld_src[k];
        end

        always_ff @(posedge clk)
        begin
            if (rdy[k])
                st_reg[k] <= st_next;
        end
    end

    assign dn_valid = vld_reg[DIV_STAGES-1];

    // zero sectors per track: whole sum is the sector, track is all ones
    always_comb
    begin
        if (cfg.sectors_per_track == '0)
        begin
            dn_word.s = st_reg[DIV_STAGES-1].a;
            dn_word.t = '1;
        end
        else
        begin
            dn_word.s = SUM_BITS'(st_reg[DIV_STAGES-1].rem);
            dn_word.t = SECTOR_NUMBER_BITS'(st_reg[DIV_STAGES-1].q);
        end
    end

endmodule

`default_nettype wire

// ----- hdl/fsst_skew.sv -----
// ---------------------------------------------------------------------------
// fsst_skew: track fold and per-format sector skew
// Stage one folds the track and takes constant quotients; stage two picks
// the skew rule and forms the track base product.
// ---------------------------------------------------------------------------
`default_nettype none

module fsst_skew import fsst_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       up_valid,
    output logic       up_ready,
    input  div_word_t  up_word,
    output logic       dn_valid,
    input  logic       dn_ready,
    output skew_word_t dn_word
);

    localparam int PROD_BITS = SUM_BITS + 16;
    localparam int Q3_BITS   = 13;
    localparam int Q5_BITS   = 12;
    localparam int Q13_BITS  = 11;
    localparam int TP_BITS   = SECTOR_NUMBER_BITS + SPT_BITS;

    logic                v4_reg;
    logic                rdy4;
    logic [SUM_BITS-1:0] s4_reg;
    sector_t             t4_reg;
    sector_t             t4_next;
    logic [Q3_BITS-1:0]  q3_reg;
    logic [Q5_BITS-1:0]  q5_reg;
    logic [Q13_BITS-1:0] q13_reg;
    logic [PROD_BITS-1:0] p3;
    logic [PROD_BITS-1:0] p5;
    logic [PROD_BITS-1:0] p13;
    sector_t             fold_diff;

    logic                v5_reg;
    logic                rdy5;
    skew_word_t          w5_reg;
    skew_word_t          w5_next;
    logic [TP_BITS-1:0]  tp;

    assign rdy5     = !v5_reg || dn_ready;
    assign rdy4     = !v4_reg || rdy5;
    assign up_ready = rdy4;
    assign dn_valid = v5_reg;
    assign dn_word  = w5_reg;

    // stage 4: constant quotients and serpentine track order
    assign p3  = PROD_BITS'(up_word.s) * PROD_BITS'(RECIP3);
    assign p5  = PROD_BITS'(up_word.s) * PROD_BITS'(RECIP5);
    assign p13 = PROD_BITS'(up_word.s) * PROD_BITS'(RECIP13);
    assign fold_diff = TRACK_TURN - up_word.t;

    always_comb
    begin
        t4_next = up_word.t;
        if (cfg.disk_inches == INCH_5 && cfg.side_count == SIDES_2 &&
            cfg.reserved_sectors == '0)
        begin
            if (up_word.t < TRACK_FOLD)
                t4_next = {up_word.t[SECTOR_NUMBER_BITS-2:0], 1'b0};
            else
                t4_next = {fold_diff[SECTOR_NUMBER_BITS-2:0], 1'b1};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else if (rdy4)
            v4_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (rdy4)
        begin
            s4_reg  <= up_word.s;
            t4_reg  <= t4_next;
            q3_reg  <= p3[SHIFT3+Q3_BITS-1:SHIFT3];
            q5_reg  <= p5[SHIFT5+Q5_BITS-1:SHIFT5];
            q13_reg <= p13[SHIFT13+Q13_BITS-1:SHIFT13];
        end
    end

    // stage 5: skew rule select and track base
    assign tp = TP_BITS'(t4_reg) * TP_BITS'(cfg.sectors_per_track);

    always_comb
    begin
        sector_t s;
        sector_t half;
        sector_t x2;
        sector_t x3;
        sector_t x4;
        sector_t x5;
        sector_t x6;
        sector_t q3;
        sector_t r3;
        sector_t lk180;
        sector_t lkdd;
        sector_t lk128;
        sector_t lk256;
        sector_t lk1024;
        logic    alt;

        s    = SECTOR_NUMBER_BITS'(s4_reg);
        half = s >> 1;
        x2   = s << 1;
        x3   = x2 + s;
        x4   = s << 2;
        x5   = x4 + s;
        x6   = x3 << 1;
        q3   = SECTOR_NUMBER_BITS'(q3_reg);
        r3   = s - (q3 + (q3 << 1));
        alt  = cfg.alternate_skew;

        // table index past the end passes the sector through
        lk180  = (s < SECTOR_NUMBER_BITS'(LEN_180))
               ? SECTOR_NUMBER_BITS'(skew5_180(s[4:0])) : s;
        lkdd   = (s < SECTOR_NUMBER_BITS'(LEN_DD))
               ? SECTOR_NUMBER_BITS'(skew5_dd(s[3:0])) : s;
        lk128  = (s < SECTOR_NUMBER_BITS'(LEN_128))
               ? SECTOR_NUMBER_BITS'(skew8_128(s[4:0])) : s;
        lk256  = (s < SECTOR_NUMBER_BITS'(LEN_256))
               ? SECTOR_NUMBER_BITS'(skew8_256(s[4:0])) : s;
        lk1024 = (s < SECTOR_NUMBER_BITS'(LEN_1024))
               ? SECTOR_NUMBER_BITS'(skew8_1024(s[2:0])) : s;

        w5_next.err   = 1'b0;
        w5_next.tprod = tp[SECTOR_NUMBER_BITS-1:0];
        if (cfg.disk_inches == INCH_5)
        begin
            if (cfg.sectors_per_track == SPT_5)
            begin
                if (cfg.bytes_per_group == BPG_2048)
                    w5_next.n = alt ? x4 : x3;
                else
                    w5_next.n = alt ? x3 : s;
            end
            else if (cfg.kilobytes_per_volume == KB_200)
                w5_next.n = alt ? s : x2 + SECTOR_NUMBER_BITS'(q5_reg);
            else if (cfg.kilobytes_per_volume == KB_320)
                w5_next.n = alt ? x4 + half : s;
            else if (cfg.kilobytes_per_volume == KB_180)
                w5_next.n = alt ? lk180 : x5;
            else if (cfg.bytes_per_sector == BPS_256)
                w5_next.n = alt ? x5 + half : s;
            else
                w5_next.n = alt ? lkdd : x5 + half;
        end
        else if (cfg.bytes_per_sector == BPS_128)
            w5_next.n = alt ? lk128 : x6 + SECTOR_NUMBER_BITS'(q13_reg);
        else if (cfg.bytes_per_sector == BPS_256)
            w5_next.n = alt ? lk256 : (r3 << 3) + r3 + q3;
        else if (cfg.bytes_per_sector == BPS_512)
            w5_next.n = alt ? x2 : x4;
        else if (cfg.bytes_per_sector == BPS_1024)
            w5_next.n = alt ? lk1024 : x3;
        else
        begin
            w5_next.n   = '0;
            w5_next.err = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v5_reg <= 1'b0;
        else if (rdy5)
            v5_reg <= v4_reg;
    end

    always_ff @(posedge clk)
    begin
        if (rdy5)
            w5_reg <= w5_next;
    end

endmodule

`default_nettype wire

// ----- hdl/fsst_place.sv -----
// ---------------------------------------------------------------------------
// fsst_place: final reduction, track rebase and byte offset
// Reduces the skewed sector, adds the track base, scales by sector size.
// ---------------------------------------------------------------------------
`default_nettype none

module fsst_place import fsst_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cfg_t                   cfg,
    input  logic                   up_valid,
    output logic                   up_ready,
    input  skew_word_t             up_word,
    output logic                   dn_valid,
    input  logic                   dn_ready,
    output sector_t                physical_sector,
    output logic [OFFSET_BITS-1:0] byte_offset,
    output logic                   size_error
);

    localparam int OFF_PROD_BITS = SECTOR_NUMBER_BITS + BPS_BITS;

    logic    v6_reg;
    logic    v7_reg;
    logic    v8_reg;
    logic    rdy6;
    logic    rdy7;
    logic    rdy8;

    sector_t nm6_reg;
    sector_t nm6_next;
    sector_t tp6_reg;
    logic    err6_reg;

    sector_t phys7_reg;
    sector_t phys7_next;
    logic    err7_reg;

    sector_t                  phys8_reg;
    logic [OFFSET_BITS-1:0]   off8_reg;
    logic                     err8_reg;
    logic [OFF_PROD_BITS-1:0] off_prod;

    assign rdy8     = !v8_reg || dn_ready;
    assign rdy7     = !v7_reg || rdy8;
    assign rdy6     = !v6_reg || rdy7;
    assign up_ready = rdy6;

    assign dn_valid        = v8_reg;
    assign physical_sector = phys8_reg;
    assign byte_offset     = off8_reg;
    assign size_error      = err8_reg;

    // stage 6: skewed sector modulo sectors per track; it fits in eight
    // bits whenever the track length is nonzero
    always_comb
    begin
        logic [SPT_BITS-1:0] rem;
        logic [SPT_BITS:0]   step;
        rem = '0;
        for (int j = NARROW_BITS - 1; j >= 0; j--)
        begin
            step = div_step(rem, up_word.n[j], cfg.sectors_per_track);
            rem  = step[SPT_BITS-1:0];
        end
        if (cfg.sectors_per_track == '0)
            nm6_next = up_word.n;
        else
            nm6_next = SECTOR_NUMBER_BITS'(rem);
    end

    // stage 7: rebase onto the track, drop the result on a size error
    assign phys7_next = err6_reg ? '0 : nm6_reg + tp6_reg;

    // stage 8: byte offset
    assign off_prod = OFF_PROD_BITS'(phys7_reg) * OFF_PROD_BITS'(cfg.bytes_per_sector);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
        end
        else
        begin
            if (rdy6)
                v6_reg <= up_valid;
            if (rdy7)
                v7_reg <= v6_reg;
            if (rdy8)
                v8_reg <= v7_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy6)
        begin
            nm6_reg  <= nm6_next;
            tp6_reg  <= up_word.tprod;
            err6_reg <= up_word.err;
        end
        if (rdy7)
        begin
            phys7_reg <= phys7_next;
            err7_reg  <= err6_reg;
        end
        if (rdy8)
        begin
            phys8_reg <= phys7_reg;
            off8_reg  <= off_prod[OFFSET_BITS-1:0];
            err8_reg  <= err7_reg;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/floppy_sector_skew_translate_unit.sv -----
// ---------------------------------------------------------------------------
// floppy_sector_skew_translate_unit: logical to physical floppy sector map
// Offset, track split, serpentine fold, format skew and byte offset.
// ---------------------------------------------------------------------------
// The unit takes one logical sector word per cycle, unless req_stall is
// high, and returns one result word per request, in order.
// The rate is set by an eight-stage pipeline: three
// stages of restoring division by sectors per track (five quotient bits
// each), two stages of track fold and skew selection, and three of
// reduction, rebase and byte-offset multiply. Every stage holds a word, so
// up to eight requests are in flight and a stalled result still lets the
// empty stages behind it fill. Format registers are written through the cfg
// port, which is always ready; write them only while no request is in
// flight. An 8-inch format with a sector size other than 128, 256, 512 or
// 1024 returns size_error with zero sector and offset.
`default_nettype none

module floppy_sector_skew_translate_unit import fsst_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      req_valid,
    output logic                      req_stall,
    input  logic [LS_BITS-1:0]        logical_sector,
    output logic                      rsp_valid,
    input  logic                      rsp_stall,
    output logic [SECTOR_NUMBER_BITS-1:0] physical_sector,
    output logic [OFFSET_BITS-1:0]    byte_offset,
    output logic                      size_error
);

    cfg_t       cfg;
    logic       div_ready;
    logic       div_valid;
    div_word_t  div_word;
    logic       skew_ready;
    logic       skew_valid;
    skew_word_t skew_word;
    logic       place_ready;

    assign req_stall = !div_ready;

    fsst_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    fsst_div u_div (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .up_valid       (req_valid),
        .up_ready       (div_ready),
        .logical_sector (logical_sector),
        .dn_valid       (div_valid),
        .dn_ready       (skew_ready),
        .dn_word        (div_word)
    );

    fsst_skew u_skew (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .up_valid (div_valid),
        .up_ready (skew_ready),
        .up_word  (div_word),
        .dn_valid (skew_valid),
        .dn_ready (place_ready),
        .dn_word  (skew_word)
    );

    fsst_place u_place (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .up_valid        (skew_valid),
        .up_ready        (place_ready),
        .up_word         (skew_word),
        .dn_valid        (rsp_valid),
        .dn_ready        (!rsp_stall),
        .physical_sector (physical_sector),
        .byte_offset     (byte_offset),
        .size_error      (size_error)
    );

endmodule

`default_nettype wire

// ----- hdl/fsst_chk.sv -----
// ---------------------------------------------------------------------------
// fsst_chk: port-level checks for the sector skew translator
// Tracks words in flight and checks the result channel over time.
// ---------------------------------------------------------------------------
`default_nettype none

module fsst_chk import fsst_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    input  logic                          req_stall,
    input  logic                          rsp_valid,
    input  logic                          rsp_stall,
    input  logic [SECTOR_NUMBER_BITS-1:0] physical_sector,
    input  logic [OFFSET_BITS-1:0]        byte_offset,
    input  logic                          size_error
);

    localparam int CNT_BITS = $clog2(PIPE_DEPTH + 1);

    logic [CNT_BITS-1:0] cnt_reg;
    logic [CNT_BITS-1:0] cnt_next;
    logic                req_acc;
    logic                rsp_acc;

    assign req_acc = req_valid && !req_stall;
    assign rsp_acc = rsp_valid && !rsp_stall;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (req_acc && !rsp_acc)
            cnt_next = cnt_reg + CNT_BITS'(1);
        else if (rsp_acc && !req_acc)
            cnt_next = cnt_reg - CNT_BITS'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid)
        else $error("result word dropped while stalled");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> $stable(physical_sector) && $stable(byte_offset)
                                   && $stable(size_error))
        else $error("stalled result word changed");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && size_error |-> physical_sector == '0 && byte_offset == '0)
        else $error("size error with nonzero result");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> cnt_reg != '0)
        else $error("result word without a request in flight");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_BITS'(PIPE_DEPTH))
        else $error("more words in flight than pipeline stages");

endmodule

bind floppy_sector_skew_translate_unit fsst_chk u_fsst_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req_valid),
    .req_stall       (req_stall),
    .rsp_valid       (rsp_valid),
    .rsp_stall       (rsp_stall),
    .physical_sector (physical_sector),
    .byte_offset     (byte_offset),
    .size_error      (size_error)
);

`default_nettype wire
